// File: src/sha1md_pkg.sv
// SHA-1 digest engine: shared types, constants and round helper functions.
// Used by sha1md_core and sha1_message_digest_top; depends on nothing.
package sha1md_pkg;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_ADD
  } core_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FINISH
  } top_state_t;

  typedef struct packed {
    logic start;
    logic init;
  } core_ctrl_t;

  localparam int unsigned NUM_ROUNDS = 80;
  localparam int unsigned BLOCK_BITS = 512;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_FILL = 6'd56;
  localparam logic [5:0] LAST_FILL = 6'd63;

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] k;
    if (rnd < 7'd20) begin
      k = K0;
    end else if (rnd < 7'd40) begin
      k = K1;
    end else if (rnd < 7'd60) begin
      k = K2;
    end else begin
      k = K3;
    end
    return k;
  endfunction

endpackage

// File: src/sha1md_core.sv
// SHA-1 compression unit: one round per cycle over a rolling 16-word schedule.
// Holds the chaining value. Depends on sha1md_pkg.
module sha1md_core (
  input  logic                   clk,
  input  logic                   rst,
  input  sha1md_pkg::core_ctrl_t ctrl,
  input  logic [511:0]           block,
  output logic                   done,
  output logic [31:0]            cv0,
  output logic [31:0]            cv1,
  output logic [31:0]            cv2,
  output logic [31:0]            cv3,
  output logic [31:0]            cv4
);

  sha1md_pkg::core_state_t state, state_next;

  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e;
  logic [31:0] cv [5];
  logic [6:0]  rnd;
  logic [31:0] tmp;
  logic [31:0] sched_x;
  logic [31:0] sched_new;

  always_comb begin
    state_next = state;
    unique case (state)
      sha1md_pkg::CORE_IDLE:  if (ctrl.start) state_next = sha1md_pkg::CORE_ROUND;
      sha1md_pkg::CORE_ROUND: begin
        if (rnd == 7'(sha1md_pkg::NUM_ROUNDS - 1)) state_next = sha1md_pkg::CORE_ADD;
      end
      sha1md_pkg::CORE_ADD:   state_next = sha1md_pkg::CORE_IDLE;
      default:                state_next = sha1md_pkg::CORE_IDLE;
    endcase
  end

  always_comb begin
    done = (state == sha1md_pkg::CORE_ADD);
  end

  assign sched_x   = w[13] ^ w[8] ^ w[2] ^ w[0];
  assign sched_new = {sched_x[30:0], sched_x[31]};
  assign tmp = {a[26:0], a[31:27]} + sha1md_pkg::round_f(rnd, b, c, d) + e
             + sha1md_pkg::round_k(rnd) + w[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha1md_pkg::CORE_IDLE;
      cv[0] <= sha1md_pkg::IV0;
      cv[1] <= sha1md_pkg::IV1;
      cv[2] <= sha1md_pkg::IV2;
      cv[3] <= sha1md_pkg::IV3;
      cv[4] <= sha1md_pkg::IV4;
    end else begin
      state <= state_next;
      if (ctrl.init) begin
        cv[0] <= sha1md_pkg::IV0;
        cv[1] <= sha1md_pkg::IV1;
        cv[2] <= sha1md_pkg::IV2;
        cv[3] <= sha1md_pkg::IV3;
        cv[4] <= sha1md_pkg::IV4;
      end else if (state == sha1md_pkg::CORE_ADD) begin
        cv[0] <= cv[0] + a;
        cv[1] <= cv[1] + b;
        cv[2] <= cv[2] + c;
        cv[3] <= cv[3] + d;
        cv[4] <= cv[4] + e;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (state == sha1md_pkg::CORE_IDLE) begin
      rnd <= '0;
      a <= cv[0];
      b <= cv[1];
      c <= cv[2];
      d <= cv[3];
      e <= cv[4];
      for (int i = 0; i < 16; i++) begin
        w[i] <= block[511 - 32*i -: 32];
      end
    end else if (state == sha1md_pkg::CORE_ROUND) begin
      rnd <= rnd + 7'd1;
      a <= tmp;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= sched_new;
    end
  end

  assign cv0 = cv[0];
  assign cv1 = cv[1];
  assign cv2 = cv[2];
  assign cv3 = cv[3];
  assign cv4 = cv[4];

endmodule

// File: src/sha1_message_digest_top.sv
// SHA-1 message digest: byte packing, padding sequencer and digest output register.
// Instantiates sha1md_core; depends on sha1md_pkg.
//
// Usage: the input channel (in_valid/in_ready) carries one transaction per step:
// data_byte with byte_valid, and end_of_message to close the message. A transaction
// with both flags low is accepted and has no effect. The output channel
// (out_valid/out_ready) carries the five digest words, one transaction per message.
// Flow: a byte that does not complete a block leaves in_ready high. The 64th byte of a
// block starts a compression: a load step, 80 rounds on the shared round unit and an
// add into the chaining value; in_ready stays low until the add is done.
// End of message shifts in the 0x80 mark and zero bytes one per cycle (up to 64),
// inserts the bit length, then compresses one or two blocks; with the output register
// free, out_valid rises once the last compression is done.
// Reset (rst, synchronous) restores the initial chaining value, clears the fill and
// length counts and drops out_valid. A digest waiting on a stalled receiver stays in
// its output register while the next message is taken in; a second digest waits in
// the core until the first is taken.
module sha1_message_digest_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word0,
  output logic [31:0] digest_word1,
  output logic [31:0] digest_word2,
  output logic [31:0] digest_word3,
  output logic [31:0] digest_word4
);

  sha1md_pkg::top_state_t state, state_next;
  sha1md_pkg::core_ctrl_t core_ctrl;

  logic [511:0] block;
  logic [5:0]   fill;
  logic [63:0]  bit_len;
  logic         mark_done;
  logic         pend_eom;
  logic         final_pass;
  logic         start_q;
  logic         core_done;
  logic [31:0]  cv0, cv1, cv2, cv3, cv4;

  logic accept;
  logic pad_len;
  logic pad_wrap;
  logic out_load;

  assign accept   = in_valid && in_ready;
  assign pad_len  = mark_done && (fill == sha1md_pkg::LEN_FILL);
  assign pad_wrap = !pad_len && (fill == sha1md_pkg::LAST_FILL);

  always_comb begin
    state_next = state;
    unique case (state)
      sha1md_pkg::ST_IDLE: begin
        if (accept) begin
          if (byte_valid && fill == sha1md_pkg::LAST_FILL) begin
            state_next = sha1md_pkg::ST_COMP;
          end else if (end_of_message) begin
            state_next = sha1md_pkg::ST_PAD;
          end
        end
      end
      sha1md_pkg::ST_PAD: begin
        if (pad_len || pad_wrap) state_next = sha1md_pkg::ST_COMP;
      end
      sha1md_pkg::ST_COMP: begin
        if (core_done) begin
          if (final_pass) begin
            state_next = sha1md_pkg::ST_FINISH;
          end else if (pend_eom) begin
            state_next = sha1md_pkg::ST_PAD;
          end else begin
            state_next = sha1md_pkg::ST_IDLE;
          end
        end
      end
      sha1md_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) state_next = sha1md_pkg::ST_IDLE;
      end
      default: state_next = sha1md_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state == sha1md_pkg::ST_IDLE);
    out_load       = (state == sha1md_pkg::ST_FINISH) && (!out_valid || out_ready);
    core_ctrl.start = start_q;
    core_ctrl.init  = out_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sha1md_pkg::ST_IDLE;
      fill       <= '0;
      bit_len    <= '0;
      mark_done  <= 1'b0;
      pend_eom   <= 1'b0;
      final_pass <= 1'b0;
      start_q    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      start_q <= (state_next == sha1md_pkg::ST_COMP) && (state != sha1md_pkg::ST_COMP);
      unique case (state)
        sha1md_pkg::ST_IDLE: begin
          if (accept) begin
            mark_done  <= 1'b0;
            final_pass <= 1'b0;
            pend_eom   <= end_of_message && byte_valid && (fill == sha1md_pkg::LAST_FILL);
            if (byte_valid) begin
              fill    <= fill + 6'd1;
              bit_len <= bit_len + 64'd8;
            end
          end
        end
        sha1md_pkg::ST_PAD: begin
          if (pad_len) begin
            fill       <= '0;
            final_pass <= 1'b1;
          end else begin
            fill      <= fill + 6'd1;
            mark_done <= 1'b1;
            // long tail: length goes into a second block
            if (pad_wrap) pend_eom <= 1'b1;
          end
        end
        sha1md_pkg::ST_COMP: begin
          if (core_done) pend_eom <= 1'b0;
        end
        sha1md_pkg::ST_FINISH: begin
          if (out_load) bit_len <= '0;
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // message block shift line and digest register, no reset needed
  always_ff @(posedge clk) begin
    if (state == sha1md_pkg::ST_IDLE && accept && byte_valid) begin
      block <= {block[503:0], data_byte};
    end else if (state == sha1md_pkg::ST_PAD) begin
      if (pad_len) begin
        block <= {block[447:0], bit_len};
      end else if (!mark_done) begin
        block <= {block[503:0], sha1md_pkg::PAD_MARK};
      end else begin
        block <= {block[503:0], 8'h00};
      end
    end
    if (out_load) begin
      digest_word0 <= cv0;
      digest_word1 <= cv1;
      digest_word2 <= cv2;
      digest_word3 <= cv3;
      digest_word4 <= cv4;
    end
  end

  sha1md_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (core_ctrl),
    .block (block),
    .done  (core_done),
    .cv0   (cv0),
    .cv1   (cv1),
    .cv2   (cv2),
    .cv3   (cv3),
    .cv4   (cv4)
  );

endmodule

// File: tb/sha1_message_digest_top_tb.sv
// Testbench for sha1_message_digest_top: byte stream in, SHA-1 digest out, both
// channels valid/ready. A directed table and random messages are checked against
// a digest predictor in this file; needs only the RTL under src/.
module sha1_message_digest_top_tb;

  localparam int unsigned ITEM_TARGET  = 1200;
  localparam int unsigned HOLD_CYCLES  = 4000;
  localparam int unsigned IDLE_LIMIT   = 20000;
  localparam int unsigned DRAIN_CYCLES = 300;

  localparam logic [31:0] H_INIT0 = 32'h67452301;
  localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
  localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
  localparam logic [31:0] H_INIT3 = 32'h10325476;
  localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;
  localparam logic [31:0] RK0 = 32'h5A827999;
  localparam logic [31:0] RK1 = 32'h6ED9EBA1;
  localparam logic [31:0] RK2 = 32'h8F1BBCDC;
  localparam logic [31:0] RK3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef logic [4:0][31:0] digest_t;

  typedef struct {
    logic [7:0] data;
    logic       bv;
    logic       eom;
    bit         known;
    digest_t    dig;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        byte_valid;
  logic        end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic [31:0] digest_word4;

  // predictor state
  logic [31:0] chain_h [5];
  logic [31:0] blk_w [16];
  int unsigned blk_fill;
  logic [63:0] bit_len;

  digest_t     pending_digests [$];
  stim_row_t   dir_rows [$];
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned mismatches = 0;
  int unsigned idle_cycles;
  bit          hold_go;
  bit          hold_done;

  sha1_message_digest_top dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .byte_valid     (byte_valid),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digest_word0   (digest_word0),
    .digest_word1   (digest_word1),
    .digest_word2   (digest_word2),
    .digest_word3   (digest_word3),
    .digest_word4   (digest_word4)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void restart_chain();
    chain_h[0] = H_INIT0;
    chain_h[1] = H_INIT1;
    chain_h[2] = H_INIT2;
    chain_h[3] = H_INIT3;
    chain_h[4] = H_INIT4;
    blk_fill = 0;
    bit_len = '0;
  endfunction

  function automatic void sha_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, tmp;
    for (int i = 0; i < 16; i++) w[i] = blk_w[i];
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        w[r % 16] = rotl(w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16] ^ w[r % 16], 1);
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RK0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RK1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RK2;
      end else begin
        f = b ^ c ^ d;
        k = RK3;
      end
      tmp = rotl(a, 5) + f + e + k + w[r % 16];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = tmp;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void pack_byte(input logic [7:0] bval);
    int unsigned sh;
    sh = (3 - blk_fill % 4) * 8;
    if (blk_fill % 4 == 0) begin
      blk_w[blk_fill / 4] = {24'd0, bval} << sh;
    end else begin
      blk_w[blk_fill / 4] |= {24'd0, bval} << sh;
    end
    blk_fill++;
    if (blk_fill == 64) begin
      sha_compress();
      blk_fill = 0;
    end
  endfunction

  // Returns 1 when the transaction closes a message; dig then holds its digest.
  function automatic bit predict_digest(input logic [7:0] bval, input logic bv,
                                        input logic eom, output digest_t dig);
    logic [63:0] len;
    dig = '0;
    if (bv) begin
      pack_byte(bval);
      bit_len += 64'd8;
    end
    if (!eom) return 1'b0;
    len = bit_len;
    pack_byte(PAD_BYTE);
    while (blk_fill != 56) pack_byte(8'h00);
    blk_w[14] = len[63:32];
    blk_w[15] = len[31:0];
    sha_compress();
    for (int j = 0; j < 5; j++) dig[j] = chain_h[j];
    restart_chain();
    return 1'b1;
  endfunction

  task automatic add_row(input logic [7:0] bval, input logic bv, input logic eom,
                         input bit known, input digest_t dig);
    stim_row_t row;
    row.data = bval;
    row.bv = bv;
    row.eom = eom;
    row.known = known;
    row.dig = dig;
    dir_rows = {dir_rows, row};
  endtask

  // Sender pacing: bursts of random length, random gaps between them.
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 30);
      @(negedge clk);
      in_valid <= 1'b0;
      data_byte <= 8'($urandom);
      repeat (gap - 1) @(negedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic offer(input logic [7:0] bval, input logic bv, input logic eom,
                       input bit known, input digest_t known_dig);
    digest_t dig;
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= bval;
    byte_valid <= bv;
    end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    if (predict_digest(bval, bv, eom, dig)) begin
      if (known) dig = known_dig;
      pending_digests = {pending_digests, dig};
    end
    if (bv || eom) items_sent++;
    pace();
  endtask

  task automatic send_message(input int unsigned len);
    bit eom_on_byte;
    eom_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) offer(8'($urandom), 1'b0, 1'b0, 1'b0, '0);
      offer(8'($urandom), 1'b1, eom_on_byte && (i == len - 1), 1'b0, '0);
    end
    if (!eom_on_byte) offer(8'($urandom), 1'b0, 1'b1, 1'b0, '0);
  endtask

  // stimulus
  initial begin : stim
    int unsigned len;
    int unsigned msgs;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    byte_valid = 1'b0;
    end_of_message = 1'b0;
    items_sent = 0;
    burst_left = 0;
    hold_go = 1'b0;
    msgs = 0;
    for (int i = 0; i < 16; i++) blk_w[i] = '0;
    restart_chain();

    // empty message
    add_row(8'h00, 1'b0, 1'b1, 1'b1,
            {32'hAFD80709, 32'h95601890, 32'h3255BFEF, 32'h5E6B4B0D, 32'hDA39A3EE});
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h61, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'hA5, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h62, 1'b1, 1'b0, 1'b0, '0);
    // "abc", end rides on the last byte
    add_row(8'h63, 1'b1, 1'b1, 1'b1,
            {32'h9CD0D89D, 32'h7850C26C, 32'hBA3E2571, 32'h4706816A, 32'hA9993E36});
    add_row(8'hFF, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h5A, 1'b0, 1'b1, 1'b0, '0);
    add_row(8'h00, 1'b1, 1'b1, 1'b0, '0);
    add_row(8'hFF, 1'b1, 1'b1, 1'b0, '0);
    add_row(8'h80, 1'b1, 1'b0, 1'b0, '0);
    add_row(8'h7F, 1'b1, 1'b1, 1'b0, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      offer(dir_rows[i].data, dir_rows[i].bv, dir_rows[i].eom, dir_rows[i].known,
            dir_rows[i].dig);
    end

    while (items_sent < ITEM_TARGET) begin
      if (msgs == 3) hold_go = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: len = $urandom_range(0, 20);
        4, 5:       len = $urandom_range(50, 70);
        6: begin
          case ($urandom_range(0, 6))
            0: len = 55;
            1: len = 56;
            2: len = 63;
            3: len = 64;
            4: len = 119;
            5: len = 120;
            default: len = 128;
          endcase
        end
        7:          len = $urandom_range(0, 8);
        default:    len = $urandom_range(20, 140);
      endcase
      send_message(len);
      msgs++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // receiver: own stall pattern, plus one long hold-off to back up the block
  initial begin : rx
    logic [31:0] rx_pat;
    int unsigned rx_mode;
    int unsigned rx_phase;
    logic        rdy;
    out_ready = 1'b0;
    hold_done = 1'b0;
    rx_phase = 0;
    rx_mode = 0;
    rx_pat = '0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        if (rx_phase == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_pat = $urandom;
          rx_phase = $urandom_range(16, 200);
        end
        rx_phase--;
        case (rx_mode)
          0:       rdy = 1'b1;
          1:       rdy = rx_pat[0];
          2:       rdy = ($urandom_range(0, 3) != 0);
          default: rdy = rx_pat[0] | rx_pat[1];
        endcase
        rx_pat = {rx_pat[0], rx_pat[31:1]};
        out_ready <= rdy;
      end
    end
  end

  always @(posedge clk) begin : check_digest
    digest_t got;
    digest_t want;
    if (!rst && out_valid && out_ready) begin
      got = {digest_word4, digest_word3, digest_word2, digest_word1, digest_word0};
      if (pending_digests.size() == 0) begin
        if (mismatches < 10) $display("unexpected digest transaction: %h", got);
        mismatches++;
      end else begin
        want = pending_digests.pop_front();
        for (int j = 0; j < 5; j++) begin
          if (got[j] !== want[j]) begin
            if (mismatches < 10) begin
              $display("digest_word%0d mismatch: expected %h, got %h", j, want[j], got[j]);
            end
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
